// ===== rtl/core/psgcmd_pkg.sv =====
// Shared types, codes and the register table of the sound-chip command decoder.
package psgcmd_pkg;

	// Input beat: stream byte, frame tick, start or stop.
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
	} in_t;

	// Result beat.
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  target_register;
		logic [7:0]  write_value;
		logic [15:0] seek_offset;
	} out_t;

	typedef enum logic [1:0] {
		MODE_BYTE  = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_START = 2'd2,
		MODE_STOP  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_PSG    = 3'd0,
		KIND_SCC    = 3'd1,
		KIND_SUSP   = 3'd2,
		KIND_SEEK   = 3'd3,
		KIND_STOP   = 3'd4,
		KIND_RESUME = 3'd5,
		KIND_IGNORE = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		CFG_RATE_50HZ = 2'd0,
		CFG_LOOP_EN   = 2'd1,
		CFG_SCC_EN    = 2'd2
	} cfg_idx_t;

	typedef enum logic [8:0] {
		PH_IDLE     = 9'b000000001,
		PH_PSG_VAL  = 9'b000000010,
		PH_F1_VAL   = 9'b000000100,
		PH_SCC_VAL  = 9'b000001000,
		PH_BLK_REG  = 9'b000010000,
		PH_BLK_CNT  = 9'b000100000,
		PH_BLK_DATA = 9'b001000000,
		PH_OFS_LO   = 9'b010000000,
		PH_OFS_HI   = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic rate_is_50hz;
		logic loop_enable;
		logic scc_enable;
	} cfg_t;

	typedef struct packed {
		logic        playing;
		logic        suspended;
		logic [7:0]  frames_to_wait;
		phase_t      phase;
		logic [7:0]  pending_register;
		logic [7:0]  block_remaining;
		logic [7:0]  offset_low_byte;
	} state_t;

	localparam logic [7:0] SCC_BASE    = 8'h80;
	localparam logic [7:0] SCC_F1_REG  = 8'h8F;
	localparam logic [7:0] SCC_F1_HIGH = 8'h10;
	localparam logic [7:0] CMD_BLOCK   = 8'hF5;
	localparam logic [7:0] CMD_F1      = 8'hF1;
	localparam logic [7:0] CMD_LOOP    = 8'hFE;
	localparam logic [7:0] CMD_END     = 8'hFF;
	localparam logic [7:0] CMD_SCC_MAX = 8'hF8;
	localparam logic [3:0] NIB_PSG_MAX = 4'hC;
	localparam logic [3:0] NIB_WAIT50  = 4'hD;
	localparam logic [3:0] NIB_WAIT60  = 4'hE;
	localparam logic [3:0] NIB_F       = 4'hF;

	// One-byte PSG form: high nibble selects the register.
	function automatic logic [7:0] psg_map(input logic [3:0] hi);
		logic [7:0] r;
		case (hi)
			4'h1: r = 8'd1;
			4'h2: r = 8'd3;
			4'h3: r = 8'd5;
			4'h4: r = 8'd6;
			4'h5: r = 8'd6;
			4'h6: r = 8'd8;
			4'h7: r = 8'd8;
			4'h8: r = 8'd9;
			4'h9: r = 8'd9;
			4'hA: r = 8'd10;
			4'hB: r = 8'd10;
			4'hC: r = 8'd13;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// Playback state after a start or a stop.
	function automatic state_t cleared(input logic playing);
		state_t s;
		s.playing          = playing;
		s.suspended        = 1'b1;
		s.frames_to_wait   = 8'd0;
		s.phase            = PH_IDLE;
		s.pending_register = 8'd0;
		s.block_remaining  = 8'd0;
		s.offset_low_byte  = 8'd0;
		return s;
	endfunction

endpackage

// ===== rtl/core/psg_music_command_decoder.sv =====
// Top level of the sound-chip command decoder: input stage, playback state and result stage.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | input     | in_valid / in_stall   | in_data (mode, data_byte)
//  out     | output    | out_valid / out_stall | out_data (kind, register, value, offset)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat per cycle unless a stall on the output holds it. A beat is held in the
// input register, is decoded against the playback state in a single pass and its
// result, if any, lands in the output register. Reset clears the playback state,
// rate_is_50hz comes up set. A stall on the output holds the output register and,
// through it, the input register; the input stalls only while both are full.
module psg_music_command_decoder (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  psgcmd_pkg::in_t  in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output psgcmd_pkg::out_t out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic             cfg_data
);

	logic               valid_s1;
	psgcmd_pkg::in_t    data_s1;
	psgcmd_pkg::cfg_t   cfg_q;
	psgcmd_pkg::state_t state_q;
	psgcmd_pkg::state_t state_nxt;
	logic               res_vld;
	psgcmd_pkg::out_t   res;
	logic               can_load;
	logic               advance;
	logic               accept;

	assign advance   = valid_s1 && can_load;
	assign in_stall  = valid_s1 && !can_load;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_is_50hz <= 1'b1;
			cfg_q.loop_enable  <= 1'b0;
			cfg_q.scc_enable   <= 1'b0;
		end else if (cfg_valid) begin
			case (psgcmd_pkg::cfg_idx_t'(cfg_index))
				psgcmd_pkg::CFG_RATE_50HZ: cfg_q.rate_is_50hz <= cfg_data;
				psgcmd_pkg::CFG_LOOP_EN:   cfg_q.loop_enable  <= cfg_data;
				psgcmd_pkg::CFG_SCC_EN:    cfg_q.scc_enable   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psgcmd_pkg::cleared(1'b0);
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	psgcmd_dec u_dec (
		.cfg     (cfg_q),
		.cur     (state_q),
		.item    (data_s1),
		.nxt     (state_nxt),
		.res_vld (res_vld),
		.res     (res)
	);

	psgcmd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_vld),
		.load_data (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/core/psgcmd_dec.sv =====
// Combinational decode of one beat: next playback state and the optional result.
module psgcmd_dec (
	input  psgcmd_pkg::cfg_t   cfg,
	input  psgcmd_pkg::state_t cur,
	input  psgcmd_pkg::in_t    item,
	output psgcmd_pkg::state_t nxt,
	output logic               res_vld,
	output psgcmd_pkg::out_t   res
);

	logic [7:0] b;
	logic [3:0] hi;
	logic [3:0] lo;
	logic [7:0] blk_left;

	assign b        = item.data_byte;
	assign hi       = b[7:4];
	assign lo       = b[3:0];
	assign blk_left = cur.block_remaining - 8'd1;

	always_comb begin
		nxt     = cur;
		res_vld = 1'b0;
		res     = '0;
		case (psgcmd_pkg::mode_t'(item.mode))
			psgcmd_pkg::MODE_STOP: begin
				nxt      = psgcmd_pkg::cleared(1'b0);
				res_vld  = 1'b1;
				res.kind = psgcmd_pkg::KIND_STOP;
			end
			psgcmd_pkg::MODE_START: begin
				// A start rewinds the feeder to the beginning of the stream.
				nxt      = psgcmd_pkg::cleared(1'b1);
				res_vld  = 1'b1;
				res.kind = psgcmd_pkg::KIND_SEEK;
			end
			psgcmd_pkg::MODE_TICK: begin
				res_vld = 1'b1;
				if (!cur.playing || !cur.suspended) begin
					res.kind = psgcmd_pkg::KIND_IGNORE;
				end else if (cur.frames_to_wait != 8'd0) begin
					nxt.frames_to_wait = cur.frames_to_wait - 8'd1;
					res.kind           = psgcmd_pkg::KIND_SUSP;
				end else begin
					nxt.suspended = 1'b0;
					res.kind      = psgcmd_pkg::KIND_RESUME;
				end
			end
			psgcmd_pkg::MODE_BYTE: begin
				if (!cur.playing || cur.suspended) begin
					res_vld  = 1'b1;
					res.kind = psgcmd_pkg::KIND_IGNORE;
				end else begin
					case (cur.phase)
						psgcmd_pkg::PH_PSG_VAL: begin
							nxt.phase           = psgcmd_pkg::PH_IDLE;
							res_vld             = 1'b1;
							res.kind            = psgcmd_pkg::KIND_PSG;
							res.target_register = cur.pending_register;
							res.write_value     = b;
						end
						psgcmd_pkg::PH_F1_VAL: begin
							nxt.phase       = psgcmd_pkg::PH_IDLE;
							res_vld         = 1'b1;
							res.kind        = psgcmd_pkg::KIND_SCC;
							res.write_value = {4'h0, lo};
							if (hi == 4'h0) begin
								res.target_register = psgcmd_pkg::SCC_F1_REG;
							end else if (hi == psgcmd_pkg::NIB_F) begin
								res.target_register = psgcmd_pkg::SCC_F1_REG;
								res.write_value     = {4'h0, lo} | psgcmd_pkg::SCC_F1_HIGH;
							end else begin
								res.target_register = psgcmd_pkg::SCC_BASE | {4'h0, hi};
							end
						end
						psgcmd_pkg::PH_SCC_VAL: begin
							nxt.phase           = psgcmd_pkg::PH_IDLE;
							res_vld             = 1'b1;
							res.kind            = psgcmd_pkg::KIND_SCC;
							res.target_register = cur.pending_register;
							res.write_value     = b;
						end
						psgcmd_pkg::PH_BLK_REG: begin
							nxt.pending_register = b;
							nxt.phase            = psgcmd_pkg::PH_BLK_CNT;
						end
						psgcmd_pkg::PH_BLK_CNT: begin
							nxt.block_remaining = b;
							nxt.phase = (b == 8'd0) ? psgcmd_pkg::PH_IDLE
							                        : psgcmd_pkg::PH_BLK_DATA;
						end
						psgcmd_pkg::PH_BLK_DATA: begin
							nxt.pending_register = cur.pending_register + 8'd1;
							nxt.block_remaining  = blk_left;
							if (blk_left == 8'd0) begin
								nxt.phase = psgcmd_pkg::PH_IDLE;
							end
							res_vld             = 1'b1;
							res.kind            = psgcmd_pkg::KIND_SCC;
							res.target_register = cur.pending_register;
							res.write_value     = b;
						end
						psgcmd_pkg::PH_OFS_LO: begin
							nxt.offset_low_byte = b;
							nxt.phase           = psgcmd_pkg::PH_OFS_HI;
						end
						psgcmd_pkg::PH_OFS_HI: begin
							nxt.phase          = psgcmd_pkg::PH_IDLE;
							nxt.suspended      = 1'b1;
							nxt.frames_to_wait = 8'd0;
							res_vld            = 1'b1;
							res.kind           = psgcmd_pkg::KIND_SEEK;
							res.seek_offset    = {b, cur.offset_low_byte};
						end
						default: begin
							// Idle: a new command byte.
							nxt.phase = psgcmd_pkg::PH_IDLE;
							if (hi == 4'h0) begin
								nxt.pending_register = {4'h0, lo};
								nxt.phase            = psgcmd_pkg::PH_PSG_VAL;
							end else if (hi <= psgcmd_pkg::NIB_PSG_MAX) begin
								res_vld             = 1'b1;
								res.kind            = psgcmd_pkg::KIND_PSG;
								res.target_register = psgcmd_pkg::psg_map(hi);
								res.write_value     = b;
							end else if ((hi == psgcmd_pkg::NIB_WAIT50 && cfg.rate_is_50hz) ||
							             (hi == psgcmd_pkg::NIB_WAIT60 && !cfg.rate_is_50hz)) begin
								nxt.frames_to_wait = cur.frames_to_wait + {4'h0, lo};
								nxt.suspended      = 1'b1;
								res_vld            = 1'b1;
								res.kind           = psgcmd_pkg::KIND_SUSP;
							end else if (hi != psgcmd_pkg::NIB_F) begin
								// Wait code for the other frame rate is skipped.
							end else if (b == psgcmd_pkg::CMD_LOOP && cfg.loop_enable) begin
								nxt.phase = psgcmd_pkg::PH_OFS_LO;
							end else if (!cfg.scc_enable || b == psgcmd_pkg::CMD_LOOP ||
							             b == psgcmd_pkg::CMD_END) begin
								nxt      = psgcmd_pkg::cleared(1'b0);
								res_vld  = 1'b1;
								res.kind = psgcmd_pkg::KIND_STOP;
							end else if (b == psgcmd_pkg::CMD_F1) begin
								nxt.phase = psgcmd_pkg::PH_F1_VAL;
							end else if (b == psgcmd_pkg::CMD_BLOCK) begin
								nxt.phase = psgcmd_pkg::PH_BLK_REG;
							end else if (!b[0] && b <= psgcmd_pkg::CMD_SCC_MAX) begin
								nxt.pending_register = psgcmd_pkg::SCC_BASE | {4'h0, lo};
								nxt.phase            = psgcmd_pkg::PH_SCC_VAL;
							end
						end
					endcase
				end
			end
			default: begin
				res_vld = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/psgcmd_obuf.sv =====
// Result register that holds a beat until the receiver takes it.
module psgcmd_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  psgcmd_pkg::out_t load_data,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_stall,
	output psgcmd_pkg::out_t out_data
);

	logic             valid_q;
	psgcmd_pkg::out_t data_q;

	// A new beat may enter when the register is empty or is being drained.
	assign can_load  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the sound-chip command decoder, with its own decoder predictor.
module tb_top;
	import psgcmd_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE      = 8;
	localparam int HOLD_LEN    = 300;
	localparam int RAND_ITEMS  = 104;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	in_t        in_data   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_t       out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic       cfg_data  = 1'b0;

	// Predictor copy of the registers and the playback state.
	bit         rate50      = 1'b1;
	bit         loop_on     = 1'b0;
	bit         scc_on      = 1'b0;
	bit         playing     = 1'b0;
	bit         suspended   = 1'b1;
	logic [7:0] frames_left = '0;
	phase_t     phase       = PH_IDLE;
	logic [7:0] pend_reg    = '0;
	logic [7:0] blk_left    = '0;
	logic [7:0] ofs_lo      = '0;
	logic [7:0] psg_reg_of [16] = '{0, 1, 3, 5, 6, 6, 8, 8, 9, 9, 10, 10, 13, 0, 0, 0};

	out_t answer_q [$];
	int   mismatches = 0;
	int   beats_sent = 0;
	int   fed_items  = 0;
	int   answers_checked = 0;
	int   idle_pct   = 0;
	int   stall_pct  = 0;
	int   hold_left  = 0;
	int   cycles     = 0;

	psg_music_command_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic clear_playback(input bit play);
		playing     = play;
		suspended   = 1'b1;
		frames_left = '0;
		phase       = PH_IDLE;
		pend_reg    = '0;
		blk_left    = '0;
		ofs_lo      = '0;
	endtask

	task automatic decode_beat(input in_t b, output bit has_ans, output out_t ans);
		logic [3:0] hi;
		logic [3:0] lo;
		logic [7:0] d;
		d       = b.data_byte;
		hi      = d[7:4];
		lo      = d[3:0];
		has_ans = 1'b1;
		ans     = '0;
		case (b.mode)
			MODE_STOP: begin
				clear_playback(1'b0);
				ans.kind = KIND_STOP;
			end
			MODE_START: begin
				clear_playback(1'b1);
				ans.kind = KIND_SEEK;
			end
			MODE_TICK: begin
				if (!playing || !suspended) begin
					ans.kind = KIND_IGNORE;
				end else if (frames_left != 0) begin
					frames_left--;
					ans.kind = KIND_SUSP;
				end else begin
					suspended = 1'b0;
					ans.kind  = KIND_RESUME;
				end
			end
			default: begin
				if (!playing || suspended) begin
					ans.kind = KIND_IGNORE;
				end else begin
					case (phase)
						PH_PSG_VAL: begin
							phase = PH_IDLE;
							ans.kind = KIND_PSG;
							ans.target_register = pend_reg;
							ans.write_value = d;
						end
						PH_F1_VAL: begin
							phase = PH_IDLE;
							ans.kind = KIND_SCC;
							ans.write_value = {4'h0, lo};
							if (hi == 4'h0 || hi == NIB_F)
								ans.target_register = SCC_F1_REG;
							else
								ans.target_register = SCC_BASE + {4'h0, hi};
							if (hi == NIB_F)
								ans.write_value = ans.write_value | SCC_F1_HIGH;
						end
						PH_SCC_VAL: begin
							phase = PH_IDLE;
							ans.kind = KIND_SCC;
							ans.target_register = pend_reg;
							ans.write_value = d;
						end
						PH_BLK_REG: begin
							pend_reg = d;
							phase = PH_BLK_CNT;
							has_ans = 1'b0;
						end
						PH_BLK_CNT: begin
							blk_left = d;
							phase = (d == 0) ? PH_IDLE : PH_BLK_DATA;
							has_ans = 1'b0;
						end
						PH_BLK_DATA: begin
							ans.kind = KIND_SCC;
							ans.target_register = pend_reg;
							ans.write_value = d;
							pend_reg++;
							blk_left--;
							if (blk_left == 0)
								phase = PH_IDLE;
						end
						PH_OFS_LO: begin
							ofs_lo = d;
							phase = PH_OFS_HI;
							has_ans = 1'b0;
						end
						PH_OFS_HI: begin
							phase = PH_IDLE;
							suspended = 1'b1;
							frames_left = '0;
							ans.kind = KIND_SEEK;
							ans.seek_offset = {d, ofs_lo};
						end
						default: begin
							has_ans = 1'b0;
							if (hi == 4'h0) begin
								pend_reg = {4'h0, lo};
								phase = PH_PSG_VAL;
							end else if (hi <= NIB_PSG_MAX) begin
								has_ans = 1'b1;
								ans.kind = KIND_PSG;
								ans.target_register = psg_reg_of[hi];
								ans.write_value = d;
							end else if (hi == NIB_WAIT50 || hi == NIB_WAIT60) begin
								// Only the wait code of the selected frame rate counts.
								if ((hi == NIB_WAIT50) == rate50) begin
									has_ans = 1'b1;
									frames_left = frames_left + {4'h0, lo};
									suspended = 1'b1;
									ans.kind = KIND_SUSP;
								end
							end else if (d == CMD_LOOP && loop_on) begin
								phase = PH_OFS_LO;
							end else if (!scc_on || d == CMD_LOOP || d == CMD_END) begin
								has_ans = 1'b1;
								clear_playback(1'b0);
								ans.kind = KIND_STOP;
							end else if (d == CMD_F1) begin
								phase = PH_F1_VAL;
							end else if (d == CMD_BLOCK) begin
								phase = PH_BLK_REG;
							end else if (!d[0] && d <= CMD_SCC_MAX) begin
								pend_reg = SCC_BASE + {4'h0, lo};
								phase = PH_SCC_VAL;
							end
						end
					endcase
				end
			end
		endcase
	endtask

	task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	task automatic check_answer(input out_t got);
		out_t want;
		answers_checked++;
		if (answer_q.size() == 0) begin
			mismatches++;
			$display("%0t: result beat with nothing expected, expected none, actual %h", $time, got);
		end else begin
			want = answer_q.pop_front();
			cmp_field("kind", 32'(want.kind), 32'(got.kind));
			cmp_field("target_register", 32'(want.target_register),
				32'(got.target_register));
			cmp_field("write_value", 32'(want.write_value), 32'(got.write_value));
			cmp_field("seek_offset", 32'(want.seek_offset), 32'(got.seek_offset));
		end
	endtask

	// Result side: check the beat taken at this edge, then choose the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_answer(out_data);
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic send_beat(input in_t b);
		bit   has_ans;
		out_t ans;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (in_stall);
		decode_beat(b, has_ans, ans);
		beats_sent++;
		if (has_ans)
			answer_q.push_back(ans);
		if (!(has_ans && ans.kind == KIND_IGNORE))
			fed_items++;
	endtask

	function automatic in_t beat_of(input mode_t m, input logic [7:0] d);
		in_t b;
		b.mode      = m;
		b.data_byte = d;
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] d);
		send_beat(beat_of(MODE_BYTE, d));
	endtask

	task automatic send_ctl(input mode_t m);
		send_beat(beat_of(m, 8'h00));
	endtask

	task automatic settle_all();
		in_valid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input bit r50, input bit lp, input bit sc);
		cfg_idx_t regs [3] = '{CFG_RATE_50HZ, CFG_LOOP_EN, CFG_SCC_EN};
		bit       vals [3];
		vals = '{r50, lp, sc};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		rate50  = r50;
		loop_on = lp;
		scc_on  = sc;
	endtask

	// Picks a byte that fits the phase the decoder is in, so that long songs get through.
	function automatic logic [7:0] next_stream_byte();
		logic [7:0] d;
		int         c;
		int         u;
		d = 8'($urandom_range(0, 255));
		case (phase)
			PH_IDLE: begin
				c = $urandom_range(0, 19);
				if (c < 4)
					d[7:4] = 4'h0;
				else if (c < 8)
					d[7:4] = 4'($urandom_range(1, NIB_PSG_MAX));
				else if (c < 10)
					d[7:4] = NIB_WAIT50;
				else if (c < 12)
					d[7:4] = NIB_WAIT60;
				else if (c == 12)
					d = CMD_F1;
				else if (c < 15)
					d = {NIB_F, 4'(2 * $urandom_range(0, 4))};
				else if (c == 15)
					d = CMD_BLOCK;
				else if (c == 16) begin
					// Undefined wave chip codes.
					u = $urandom_range(0, 6);
					d = {NIB_F, (u == 0) ? 4'h3 : (u == 1) ? 4'h7 : 4'(u + 7)};
				end else if (c == 17)
					d = CMD_LOOP;
				else if (c == 18)
					d = CMD_END;
			end
			PH_BLK_CNT: begin
				if ($urandom_range(0, 29) != 0)
					d = 8'($urandom_range(0, 4));
			end
			default: ;
		endcase
		return d;
	endfunction

	function automatic in_t pick_beat();
		int  r;
		in_t b;
		r = $urandom_range(0, 99);
		b.mode = MODE_BYTE;
		b.data_byte = 8'($urandom_range(0, 255));
		if (r < 6)
			b.mode = 2'($urandom_range(0, 3));
		else if (!playing)
			b.mode = (r < 9) ? MODE_STOP : MODE_START;
		else if (r < 8)
			b.mode = MODE_STOP;
		else if (r < 10)
			b.mode = MODE_START;
		else if (suspended || r < 13)
			b.mode = MODE_TICK;
		else
			b.data_byte = next_stream_byte();
		return b;
	endfunction

	task automatic test_stopped_rules();
		send_byte(8'h00);
		send_beat(beat_of(MODE_TICK, 8'hFF));
		send_ctl(MODE_STOP);
		send_ctl(MODE_START);
		send_byte(8'h1A);
		send_ctl(MODE_TICK);
		send_ctl(MODE_TICK);
		settle_all();
	endtask

	task automatic test_psg_and_waits();
		send_byte(8'h0F);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h1A);
		send_byte(8'hC5);
		send_byte({NIB_WAIT60, 4'h3});
		send_byte({NIB_WAIT50, 4'h0});
		send_ctl(MODE_TICK);
		send_byte({NIB_WAIT50, 4'h2});
		repeat (3) send_ctl(MODE_TICK);
		send_byte(CMD_F1);
		send_byte(8'h55);
		settle_all();
	endtask

	task automatic test_scc_and_loop();
		set_config(1'b0, 1'b1, 1'b1);
		send_ctl(MODE_START);
		send_ctl(MODE_TICK);
		send_byte(CMD_F1);
		send_byte(8'h05);
		send_byte(CMD_F1);
		send_byte(8'hF3);
		send_byte(CMD_F1);
		send_byte(8'h7A);
		send_byte({NIB_F, 4'h8});
		send_byte(8'hAA);
		// Block write whose register number wraps past the top.
		send_byte(CMD_BLOCK);
		send_byte(8'hFF);
		send_byte(8'h02);
		send_byte(8'hAA);
		send_byte(8'h5B);
		send_byte(CMD_BLOCK);
		send_byte(8'h10);
		send_byte(8'h00);
		send_byte({NIB_F, 4'h3});
		send_byte({NIB_WAIT50, 4'h5});
		send_byte({NIB_WAIT60, 4'h0});
		send_ctl(MODE_TICK);
		send_byte(CMD_LOOP);
		send_byte(8'h34);
		send_byte(8'h12);
		send_ctl(MODE_TICK);
		send_byte(CMD_END);
		settle_all();
	endtask

	// The result side holds off for a long stretch while beats keep coming.
	task automatic test_output_hold();
		idle_pct  = 0;
		stall_pct = 0;
		@(negedge clk);
		hold_left = HOLD_LEN;
		@(posedge clk);
		send_ctl(MODE_START);
		send_ctl(MODE_TICK);
		repeat (40)
			send_byte({4'($urandom_range(1, NIB_PSG_MAX)), 4'($urandom_range(0, 15))});
		settle_all();
	endtask

	task automatic test_random_traffic(input int idle_s, input int stall_r,
			input logic [2:0] regs, input int n);
		int first;
		set_config(regs[0], regs[1], regs[2]);
		idle_pct  = idle_s;
		stall_pct = stall_r;
		first = fed_items;
		while (fed_items - first < n)
			send_beat(pick_beat());
		settle_all();
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int idle_of  [4] = '{0, 58, 0, 24};
		int stall_of [4] = '{0, 0, 58, 24};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_stopped_rules();
		test_psg_and_waits();
		test_scc_and_loop();
		test_output_hold();
		// Every register combination, two per idling mix.
		for (int i = 0; i < 8; i++)
			test_random_traffic(idle_of[i / 2], stall_of[i / 2], 3'(i), RAND_ITEMS);
		$display("Sent %0d beats (%0d acted upon) and checked %0d results in %0d cycles.",
			beats_sent, fed_items, answers_checked, cycles);
		$display("Covered all eight register settings, four idling mixes and a long output hold.");
		if (mismatches == 0 && answer_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/psgcmd_pkg.sv
rtl/core/psgcmd_dec.sv
rtl/core/psgcmd_obuf.sv
rtl/core/psg_music_command_decoder.sv
sim/tb_top.sv
